// ----- design/bf16_multiply_truncate_unit_defines.svh -----
// Assertion macros for the bf16 multiply unit.
// Used by the top level; no other dependencies.
`ifndef BF16_MULTIPLY_TRUNCATE_UNIT_DEFINES_SVH
`define BF16_MULTIPLY_TRUNCATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BMT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`else
`define BMT_ASSERT(label, clk, rst_n, prop, msg)
`endif
`endif

// ----- design/bmt_pkg.sv -----
// Package for the bf16 multiply unit: field widths and bf16 constants.
// No dependencies.
package bmt_pkg;
  localparam int unsigned BfW = 16;
  localparam logic [15:0] QuietBit   = 16'h0040;
  localparam logic [15:0] InfZeroNan = 16'hFFC0;
  localparam logic [14:0] InfMag     = 15'h7F80;
endpackage

// ----- design/bmt_core.sv -----
// Combinational bf16 product: binary32 multiply with RNE, upper half kept.
// Depends on bmt_pkg.
module bmt_core (
  input  logic [bmt_pkg::BfW-1:0] a_i,
  input  logic [bmt_pkg::BfW-1:0] b_i,
  output logic [bmt_pkg::BfW-1:0] p_o
);
  import bmt_pkg::*;

  logic        sgn, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ma, mb;
  logic [15:0] prod;
  logic signed [10:0] biased;   // e + n - 1 + 127
  logic signed [10:0] sh;       // e + 149
  logic [6:0]  frac;
  logic [4:0]  rs;
  logic [15:0] rem, half;
  logic [23:0] q;               // subnormal result in units of 2^-149
  logic [15:0] mask;

  always_comb begin
    sgn    = a_i[15] ^ b_i[15];
    a_nan  = (a_i[14:7] == 8'hFF) && (a_i[6:0] != 7'd0);
    b_nan  = (b_i[14:7] == 8'hFF) && (b_i[6:0] != 7'd0);
    a_inf  = (a_i[14:7] == 8'hFF) && (a_i[6:0] == 7'd0);
    b_inf  = (b_i[14:7] == 8'hFF) && (b_i[6:0] == 7'd0);
    a_zero = (a_i[14:0] == 15'd0);
    b_zero = (b_i[14:0] == 15'd0);
    ma = {(a_i[14:7] != 8'd0), a_i[6:0]};
    mb = {(b_i[14:7] != 8'd0), b_i[6:0]};
    prod = 16'(ma) * 16'(mb);
    // sh = e + 149, subnormal input uses exponent 1
    sh = 11'(signed'({3'b0, (a_i[14:7] == 8'd0) ? 8'd1 : a_i[14:7]}))
       + 11'(signed'({3'b0, (b_i[14:7] == 8'd0) ? 8'd1 : b_i[14:7]})) - 11'sd119;
    // value = prod * 2^(sh-149)
    // leading-one position n-1; normalized biased = sh - 149 + n - 1 + 127
    frac = 7'd0; biased = '0;
    q = 24'd0; rs = 5'd0; rem = 16'd0; half = 16'd0; mask = 16'd0;
    p_o = 16'd0;
    if (a_nan) p_o = a_i | QuietBit;
    else if (b_nan) p_o = b_i | QuietBit;
    else if (a_inf || b_inf) p_o = (a_zero || b_zero) ? InfZeroNan : {sgn, InfMag};
    else if (a_zero || b_zero) p_o = {sgn, 15'd0};
    else begin
      // leading one position l (0..15), biased = sh - 22 + l
      biased = sh - 11'sd22;
      frac = 7'd0;
      for (int i = 0; i < 16; i++) begin
        if (prod[i]) begin
          biased = sh - 11'sd22 + 11'(i);
          frac = 7'((prod << (15 - i)) >> 8);
        end
      end
      if (biased >= 11'sd255) p_o = {sgn, InfMag};
      else if (biased >= 11'sd1) p_o = {sgn, biased[7:0], frac};
      else begin
        if (sh >= 11'sd0) q = 24'(prod) << sh[4:0];
        else if (sh < -11'sd20) q = 24'd0;
        else if (sh < -11'sd16) q = 24'd0; // shifted off: rem < half always
        else begin
          rs = 5'(-sh);
          mask = 16'((17'd1 << rs) - 17'd1);
          rem = prod & mask;
          half = 16'(17'd1 << (rs - 5'd1));
          q = 24'(prod >> rs);
          if (rem > half || (rem == half && q[0])) q = q + 24'd1;
        end
        p_o = {sgn, 7'd0, q[23:16]};
      end
    end
  end
endmodule

// ----- design/bf16_multiply_truncate_unit.sv -----
// Top level of the bf16 multiply unit: input register, core, result register.
// Depends on bmt_pkg, bmt_core and the defines header.
//
// Usage: drive a_value_i, b_value_i, last_element_i with start_i high; busy_o
// is always low, so a word is taken every cycle. After acceptance the word
// passes the input register, then the result register, and the result appears
// on product_o and last_out_o with done_o high for exactly one cycle.
// Throughput is one word per cycle, with two register stages around the
// single combinational multiply. Reset clears the valid bits of both stages,
// so no result is produced until a word is accepted. The receiver cannot
// stall; every result is presented exactly once.
`include "bf16_multiply_truncate_unit_defines.svh"
module bf16_multiply_truncate_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [bmt_pkg::BfW-1:0] a_value_i,
  input  logic [bmt_pkg::BfW-1:0] b_value_i,
  input  logic                    last_element_i,
  output logic                    done_o,
  output logic [bmt_pkg::BfW-1:0] product_o,
  output logic                    last_out_o
);
  import bmt_pkg::*;

  logic           in_vld_q, out_vld_q, in_last_q, out_last_q;
  logic [BfW-1:0] a_q, b_q, p_d, p_q;

  assign busy_o = 1'b0;

  bmt_core u_core (.a_i(a_q), .b_i(b_q), .p_o(p_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q       <= a_value_i;
      b_q       <= b_value_i;
      in_last_q <= last_element_i;
    end
    if (in_vld_q) begin
      p_q        <= p_d;
      out_last_q <= in_last_q;
    end
  end

  assign done_o     = out_vld_q;
  assign product_o  = p_q;
  assign last_out_o = out_last_q;

  `BMT_ASSERT(a_done_follows, clk_i, rst_ni, start_i |=> ##1 done_o, "word lost")
  `BMT_ASSERT(a_no_spurious, clk_i, rst_ni, done_o |-> $past(start_i, 2), "extra result")
  `BMT_ASSERT(a_last_kept, clk_i, rst_ni, start_i |=> ##1 (last_out_o == $past(last_element_i, 2)), "last flag")
endmodule
